// ===== rtl/core/pjsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG scan cropper package
// Shared widths, marker byte values, reason codes and stage structs.
// ----------------------------------------------------------------------------
package pjsc_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int BYTE_BITS   = 8;

    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [BYTE_BITS-1:0] LEAD_BYTE = 8'hFF;
    localparam logic [BYTE_BITS-1:0] END_BYTE  = 8'hD9;
    localparam logic [BYTE_BITS-1:0] SCAN_BYTE = 8'hDA;

    typedef enum logic [1:0] {
        REASON_FITS     = 2'd0,
        REASON_END_MARK = 2'd1,
        REASON_NO_SCAN  = 2'd2,
        REASON_CUT_SCAN = 2'd3
    } reason_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last;
    } beat_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] crop_length;
        reason_t                reason;
        logic                   patch_eoi;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/progressive_jpeg_scan_cropper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Progressive JPEG scan cropper
// Finds where to cut a JPEG frame so that it fits a byte limit.
// ----------------------------------------------------------------------------
// The frame enters one byte per beat on the s_ channel, with s_tlast on its
// final byte. The limit is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block does not
// enforce. Reset sets it to the largest value. For each frame one beat leaves
// on the m_ channel from the result register, which the scanner loads as it
// takes the last byte from the input register: the crop length in m_tdata, and
// the reason code and the end-marker patch flag in m_tuser. Each byte passes
// an input register and is scanned against the frame state. Throughput is one
// byte per cycle; only the result register limits it: a last byte waits in the
// input register while the receiver stalls the previous result; s_tready drops.
// Synchronous reset clears the frame state and drops both valid flags.
// ----------------------------------------------------------------------------
module progressive_jpeg_scan_cropper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [23:0] crop_length
    output logic [2:0]       m_tuser    // [1:0] reason, [2] patch_eoi
);

    pjsc_pkg::beat_t   s_beat;
    pjsc_pkg::beat_t   beat;
    logic              beat_valid;
    logic              advance;
    pjsc_pkg::result_t res;

    assign s_beat.data_byte = s_tdata;
    assign s_beat.last      = s_tlast;

    pjsc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    pjsc_scanner u_scanner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .advance     (advance),
        .res_ready   (m_tready),
        .res_valid   (m_tvalid),
        .res         (res)
    );

    assign m_tdata = res.crop_length;
    assign m_tuser = {res.patch_eoi, res.reason};

    a_reset_clears_output: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_patch_only_on_scan_cut: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == pjsc_pkg::REASON_CUT_SCAN)))
        else $error("patch flag does not match reason");

    a_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != '0))
        else $error("zero crop length");

    a_scanner_takes_held_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> beat_valid)
        else $error("accepted beat not held for the scanner");

endmodule
`default_nettype wire

// ===== rtl/core/pjsc_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG scan cropper input stage
// Registers one incoming beat and holds it until the scanner takes it.
// ----------------------------------------------------------------------------
module pjsc_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire pjsc_pkg::beat_t s_beat,
    input  wire logic           advance,
    output logic                beat_valid,
    output pjsc_pkg::beat_t     beat
);

    logic            valid_reg;
    logic            valid_next;
    pjsc_pkg::beat_t beat_reg;
    pjsc_pkg::beat_t beat_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                beat_next = s_beat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pjsc_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG scan cropper marker scanner
// Tracks markers and scan starts per frame and registers the crop decision.
// ----------------------------------------------------------------------------
module pjsc_scanner (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pjsc_pkg::LENGTH_BITS-1:0]  cfg_wr_data,
    input  wire logic                              beat_valid,
    input  wire pjsc_pkg::beat_t                   beat,
    output logic                                   advance,
    input  wire logic                              res_ready,
    output logic                                   res_valid,
    output pjsc_pkg::result_t                      res
);

    localparam int LB = pjsc_pkg::LENGTH_BITS;

    logic [LB-1:0]     limit_cfg_reg;
    logic [LB-1:0]     pos_reg, pos_next;
    logic              lead_reg, lead_next;
    logic [LB-1:0]     scan_start_reg, scan_start_next;
    logic [1:0]        scan_count_reg, scan_count_next;
    logic              decided_reg, decided_next;
    logic [LB-1:0]     decided_len_reg, decided_len_next;
    logic              decided_end_reg, decided_end_next;
    logic              res_valid_reg, res_valid_next;
    pjsc_pkg::result_t res_reg, res_next;

    logic [LB-1:0] limit;
    logic [LB-1:0] frame_len;
    logic          pair_seen;
    logic          in_window;
    logic          is_end;
    logic          is_scan;

    assign limit     = (limit_cfg_reg == '0) ? LB'(1) : limit_cfg_reg;
    assign frame_len = (pos_reg == pjsc_pkg::POS_MAX) ? pos_reg : pos_reg + LB'(1);
    assign pair_seen = lead_reg && (pos_reg != '0) && !decided_reg;
    assign in_window = pos_reg < limit;
    assign is_end    = beat.data_byte == pjsc_pkg::END_BYTE;
    assign is_scan   = beat.data_byte == pjsc_pkg::SCAN_BYTE;
    assign advance   = beat_valid && (!beat.last || !res_valid_reg || res_ready);

    always_comb begin
        pos_next         = pos_reg;
        lead_next        = lead_reg;
        scan_start_next  = scan_start_reg;
        scan_count_next  = scan_count_reg;
        decided_next     = decided_reg;
        decided_len_next = decided_len_reg;
        decided_end_next = decided_end_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;

        if (advance) begin
            if (pair_seen) begin
                if (in_window) begin
                    if (is_end) begin
                        decided_next     = 1'b1;
                        decided_len_next = pos_reg;
                        decided_end_next = 1'b1;
                    end else if (is_scan) begin
                        scan_start_next = pos_reg - LB'(1);
                        if (scan_count_reg != 2'd2) begin
                            scan_count_next = scan_count_reg + 2'd1;
                        end
                    end
                end else if (scan_count_reg == 2'd1) begin
                    if (is_end) begin
                        decided_next     = 1'b1;
                        decided_len_next = pos_reg;
                        decided_end_next = 1'b1;
                    end else if (is_scan) begin
                        scan_start_next  = pos_reg - LB'(1);
                        decided_next     = 1'b1;
                        decided_len_next = pos_reg;
                        decided_end_next = 1'b0;
                    end
                end
            end
            lead_next = beat.data_byte == pjsc_pkg::LEAD_BYTE;

            if (beat.last) begin
                res_valid_next     = 1'b1;
                res_next.patch_eoi = 1'b0;
                if (limit >= frame_len) begin
                    res_next.crop_length = frame_len;
                    res_next.reason      = pjsc_pkg::REASON_FITS;
                end else if (decided_next) begin
                    res_next.crop_length = decided_len_next;
                    if (decided_end_next) begin
                        res_next.reason = pjsc_pkg::REASON_END_MARK;
                    end else begin
                        res_next.reason    = pjsc_pkg::REASON_CUT_SCAN;
                        res_next.patch_eoi = 1'b1;
                    end
                end else if (scan_count_next == 2'd0) begin
                    res_next.crop_length = frame_len;
                    res_next.reason      = pjsc_pkg::REASON_NO_SCAN;
                end else begin
                    res_next.crop_length = scan_start_next + LB'(1);
                    res_next.reason      = pjsc_pkg::REASON_CUT_SCAN;
                    res_next.patch_eoi   = 1'b1;
                end
                pos_next         = '0;
                lead_next        = 1'b0;
                scan_start_next  = '0;
                scan_count_next  = 2'd0;
                decided_next     = 1'b0;
                decided_len_next = '0;
                decided_end_next = 1'b0;
            end else begin
                pos_next = frame_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_cfg_reg   <= pjsc_pkg::POS_MAX;
            pos_reg         <= '0;
            lead_reg        <= 1'b0;
            scan_start_reg  <= '0;
            scan_count_reg  <= 2'd0;
            decided_reg     <= 1'b0;
            decided_len_reg <= '0;
            decided_end_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_cfg_reg <= cfg_wr_data;
            end
            pos_reg         <= pos_next;
            lead_reg        <= lead_next;
            scan_start_reg  <= scan_start_next;
            scan_count_reg  <= scan_count_next;
            decided_reg     <= decided_next;
            decided_len_reg <= decided_len_next;
            decided_end_reg <= decided_end_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG scan cropper testbench
// Streams JPEG-like frames one byte per beat through the cropper. A model of
// the frame state predicts each crop result, and the results that come back
// are compared field by field with it (typed table rows: with the table's).
// The run starts with a short table of frames, then phases with different
// byte limits and different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
    import pjsc_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 110;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_RESULT  = '{crop_length: 24'd0, reason: REASON_FITS,
                                       patch_eoi: 1'b0};
    localparam result_t FITS_2     = '{crop_length: 24'd2, reason: REASON_FITS,
                                       patch_eoi: 1'b0};
    localparam result_t END_MARK_2 = '{crop_length: 24'd2, reason: REASON_END_MARK,
                                       patch_eoi: 1'b0};
    localparam result_t NO_SCAN_5  = '{crop_length: 24'd5, reason: REASON_NO_SCAN,
                                       patch_eoi: 1'b0};

    // All frames below run with a limit of four bytes.
    localparam dir_row_t DIRECTED_ROWS [25] = '{
        '{8'hD8, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, FITS_2},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, END_MARK_2},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, NO_SCAN_5},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hDA, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hDA, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hDA, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hDA, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    // Frame state of the cropper as the predictor sees it.
    logic [23:0] crop_limit = POS_MAX;
    logic [23:0] byte_pos   = '0;
    logic        lead_seen  = 1'b0;
    logic [23:0] scan_pos   = '0;
    logic [1:0]  scan_cnt   = '0;
    logic        cut_known  = 1'b0;
    logic [23:0] cut_len    = '0;
    logic        cut_by_eoi = 1'b0;

    result_t    expected_crops [$];
    logic [7:0] frame_bytes [$];
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    int         bytes_sent   = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    progressive_jpeg_scan_cropper DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic bit predict_crop(input logic [7:0] b, input logic is_last,
                                        output result_t r);
        logic [23:0] p;
        logic [23:0] lim;
        logic [23:0] len;
        p   = byte_pos;
        lim = (crop_limit == '0) ? 24'd1 : crop_limit;
        r   = NO_RESULT;
        if (lead_seen && p >= 24'd1 && !cut_known) begin
            if (p < lim) begin
                if (b == END_BYTE) begin
                    cut_known  = 1'b1;
                    cut_len    = p;
                    cut_by_eoi = 1'b1;
                end else if (b == SCAN_BYTE) begin
                    scan_pos = p - 24'd1;
                    if (scan_cnt < 2'd2) scan_cnt = scan_cnt + 2'd1;
                end
            end else if (scan_cnt == 2'd1) begin
                if (b == END_BYTE) begin
                    cut_known  = 1'b1;
                    cut_len    = p;
                    cut_by_eoi = 1'b1;
                end else if (b == SCAN_BYTE) begin
                    scan_pos   = p - 24'd1;
                    cut_known  = 1'b1;
                    cut_len    = p;
                    cut_by_eoi = 1'b0;
                end
            end
        end
        lead_seen = (b == LEAD_BYTE);
        if (!is_last) begin
            if (p != POS_MAX) byte_pos = p + 24'd1;
            return 1'b0;
        end
        len = (p != POS_MAX) ? p + 24'd1 : POS_MAX;
        if (lim >= len) begin
            r.crop_length = len;
            r.reason      = REASON_FITS;
        end else if (cut_known) begin
            r.crop_length = cut_len;
            r.reason      = cut_by_eoi ? REASON_END_MARK : REASON_CUT_SCAN;
            r.patch_eoi   = !cut_by_eoi;
        end else if (scan_cnt == 2'd0) begin
            r.crop_length = len;
            r.reason      = REASON_NO_SCAN;
        end else begin
            r.crop_length = scan_pos + 24'd1;
            r.reason      = REASON_CUT_SCAN;
            r.patch_eoi   = 1'b1;
        end
        byte_pos   = '0;
        lead_seen  = 1'b0;
        scan_pos   = '0;
        scan_cnt   = '0;
        cut_known  = 1'b0;
        cut_len    = '0;
        cut_by_eoi = 1'b0;
        return 1'b1;
    endfunction

    // Mostly marker-rich frames with a start-of-image header, some pure noise.
    function automatic void build_frame(input int len);
        int pick;
        int run;
        frame_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            repeat (len) frame_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 99) < 85) begin
            frame_bytes.push_back(LEAD_BYTE);
            frame_bytes.push_back(8'hD8);
        end
        while (frame_bytes.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                frame_bytes.push_back(LEAD_BYTE);
                frame_bytes.push_back(SCAN_BYTE);
            end else if (pick < 30) begin
                frame_bytes.push_back(LEAD_BYTE);
                frame_bytes.push_back(END_BYTE);
            end else if (pick < 36) begin
                frame_bytes.push_back(LEAD_BYTE);
                frame_bytes.push_back(LEAD_BYTE);
            end else if (pick < 40) begin
                frame_bytes.push_back(LEAD_BYTE);
                frame_bytes.push_back(8'($urandom));
            end else begin
                run = $urandom_range(1, 6);
                repeat (run) frame_bytes.push_back(8'($urandom));
            end
        end
        while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        if (predict_crop(b, is_last, predicted))
            expected_crops.push_back(typed ? want : predicted);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic write_limit(input logic [23:0] value);
        while (expected_crops.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        crop_limit = value;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_crops.size() == 0) begin
                $display("%0t: unexpected result beat crop_length=%0d reason=%0d patch_eoi=%0d",
                         $time, m_tdata, m_tuser[1:0], m_tuser[2]);
                fail_count++;
            end else begin
                want = expected_crops.pop_front();
                if (m_tdata !== want.crop_length) begin
                    $display("%0t: crop_length expected %0d actual %0d",
                             $time, want.crop_length, m_tdata);
                    fail_count++;
                end
                if (m_tuser[1:0] !== want.reason) begin
                    $display("%0t: reason expected %0d actual %0d",
                             $time, want.reason, m_tuser[1:0]);
                    fail_count++;
                end
                if (m_tuser[2] !== want.patch_eoi) begin
                    $display("%0t: patch_eoi expected %0d actual %0d",
                             $time, want.patch_eoi, m_tuser[2]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [23:0] phase_limits [8];
        int          len;
        phase_limits = '{24'd1, 24'd0, POS_MAX, 24'd2, 24'd6, 24'd13, 24'd20,
                         24'($urandom_range(3, 40))};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        write_limit(24'd4);
        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            write_limit(phase_limits[ph]);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120)
                                                   : $urandom_range(1, 28);
                build_frame(len);
                foreach (frame_bytes[k]) begin
                    send_byte(frame_bytes[k], k == frame_bytes.size() - 1,
                              1'b0, NO_RESULT);
                end
            end
            s_tvalid <= 1'b0;
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (expected_crops.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_crops.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_crops.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
